/* hw/rtl/utcd_pkg.sv */
// Shared types and constants for the timestamp-to-date converter.
// Used by utcd_ctrl, utcd_dpath and the top level; depends on nothing.
`default_nettype none

package utcd_pkg;

	localparam int unsigned TS_W    = 32;
	localparam int unsigned SOD_W   = 17;
	localparam int unsigned REMH_W  = 12;
	localparam int unsigned DAYS_W  = 16;
	localparam int unsigned YEAR_W  = 12;
	localparam int unsigned MONTH_W = 4;
	localparam int unsigned DAY_W   = 5;
	localparam int unsigned HOUR_W  = 5;
	localparam int unsigned MIN_W   = 6;
	localparam int unsigned SEC_W   = 6;

	// Division by a constant through a reciprocal: x / (2^s * d) equals
	// ((x >> s) * ceil(2^k / d)) >> k, exact over each operand range used here
	localparam int unsigned DQ_W    = 25;  // timestamp >> 7
	localparam int unsigned DR_W    = 26;
	localparam int unsigned DAY_SH  = 35;
	localparam int unsigned HQ_W    = 13;  // seconds of day >> 4
	localparam int unsigned HR_W    = 14;
	localparam int unsigned HOUR_SH = 21;
	localparam int unsigned MQ_W    = 10;  // seconds of hour >> 2
	localparam int unsigned MR_W    = 11;
	localparam int unsigned MIN_SH  = 14;

	localparam logic [DR_W-1:0] RECIP_DAY  = 26'd50903317;  // ceil(2^35 / 675)
	localparam logic [HR_W-1:0] RECIP_HOUR = 14'd9321;      // ceil(2^21 / 225)
	localparam logic [MR_W-1:0] RECIP_MIN  = 11'd1093;      // ceil(2^14 / 15)

	localparam logic [TS_W-1:0]   SEC_PER_DAY  = 32'd86400;
	localparam logic [SOD_W-1:0]  SEC_PER_HOUR = 17'd3600;
	localparam logic [REMH_W-1:0] SEC_PER_MIN  = 12'd60;

	localparam logic [YEAR_W-1:0]  EPOCH_YEAR = 12'd1970;
	localparam logic [YEAR_W-1:0]  SKIP_YEAR  = 12'd2100;
	localparam logic [DAYS_W-1:0]  DAYS_YEAR  = 16'd365;
	localparam logic [DAYS_W-1:0]  DAYS_LEAP  = 16'd366;
	localparam logic [DAYS_W-1:0]  DAYS_QUAD  = 16'd1461;
	localparam logic [MONTH_W-1:0] LAST_MONTH = 4'd11;

	typedef struct packed {
		logic load_in;
		logic div_day;
		logic rem_day;
		logic div_hour;
		logic rem_hour;
		logic div_min;
		logic latch_sec;
		logic year_step;
		logic month_step;
		logic out_load;
	} cmd_t;

	typedef struct packed {
		logic year_done;
		logic month_done;
		logic out_busy;
	} status_t;

	function automatic logic [DAY_W-1:0] month_len(input logic [MONTH_W-1:0] idx,
		input logic leap);
		logic [DAY_W-1:0] len;
		unique case (idx) inside
			4'd1:                      len = leap ? 5'd29 : 5'd28;
			4'd3, 4'd5, 4'd8, 4'd10:   len = 5'd30;
			default:                   len = 5'd31;
		endcase
		return len;
	endfunction

endpackage

`default_nettype wire

/* hw/rtl/utcd_ctrl.sv */
// Sequencer for the converter: walks divide, year and month passes.
// Depends on utcd_pkg; drives utcd_dpath through cmd_t, reads status_t.
`default_nettype none

module utcd_ctrl (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             ts_valid,
	output logic                  ts_stall,
	input  utcd_pkg::status_t     status,
	output utcd_pkg::cmd_t        cmd
);
	import utcd_pkg::*;

	typedef enum logic [9:0] {
		ST_IDLE  = 10'b0000000001,
		ST_DDAY  = 10'b0000000010,
		ST_RDAY  = 10'b0000000100,
		ST_DHOUR = 10'b0000001000,
		ST_RHOUR = 10'b0000010000,
		ST_DMIN  = 10'b0000100000,
		ST_LSEC  = 10'b0001000000,
		ST_YEAR  = 10'b0010000000,
		ST_MONTH = 10'b0100000000,
		ST_FIN   = 10'b1000000000
	} state_t;

	state_t state_q, state_d;

	assign ts_stall = (state_q != ST_IDLE);

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		unique case (state_q)
			ST_IDLE: begin
				if (ts_valid) begin
					cmd.load_in = 1'b1;
					state_d = ST_DDAY;
				end
			end
			ST_DDAY: begin
				cmd.div_day = 1'b1;
				state_d = ST_RDAY;
			end
			ST_RDAY: begin
				cmd.rem_day = 1'b1;
				state_d = ST_DHOUR;
			end
			ST_DHOUR: begin
				cmd.div_hour = 1'b1;
				state_d = ST_RHOUR;
			end
			ST_RHOUR: begin
				cmd.rem_hour = 1'b1;
				state_d = ST_DMIN;
			end
			ST_DMIN: begin
				cmd.div_min = 1'b1;
				state_d = ST_LSEC;
			end
			ST_LSEC: begin
				cmd.latch_sec = 1'b1;
				state_d = ST_YEAR;
			end
			ST_YEAR: begin
				cmd.year_step = 1'b1;
				if (status.year_done) state_d = ST_MONTH;
			end
			ST_MONTH: begin
				cmd.month_step = 1'b1;
				if (status.month_done) state_d = ST_FIN;
			end
			ST_FIN: begin
				// hold until the output register is free
				if (!status.out_busy) begin
					cmd.out_load = 1'b1;
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

`default_nettype wire

/* hw/rtl/utcd_dpath.sv */
// Datapath: reciprocal dividers, year and month counters, output register.
// Depends on utcd_pkg; commanded by utcd_ctrl.
`default_nettype none

module utcd_dpath (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  utcd_pkg::cmd_t                        cmd,
	output utcd_pkg::status_t                     status,
	input  wire logic [utcd_pkg::TS_W-1:0]        unix_seconds,
	output logic                                  date_valid,
	input  wire logic                             date_stall,
	output logic [utcd_pkg::YEAR_W-1:0]           year,
	output logic [utcd_pkg::MONTH_W-1:0]          month,
	output logic [utcd_pkg::DAY_W-1:0]            day,
	output logic [utcd_pkg::HOUR_W-1:0]           hour,
	output logic [utcd_pkg::MIN_W-1:0]            minute,
	output logic [utcd_pkg::SEC_W-1:0]            second
);
	import utcd_pkg::*;

	logic [TS_W-1:0]    ts_q;
	logic [SOD_W-1:0]   sod_q;
	logic [REMH_W-1:0]  remh_q;
	logic [DAYS_W-1:0]  days_q;
	logic [HOUR_W-1:0]  hour_q;
	logic [MIN_W-1:0]   min_q;
	logic [SEC_W-1:0]   sec_q;
	logic [YEAR_W-1:0]  year_q;
	logic [MONTH_W-1:0] mon_q;
	logic               out_valid_q;

	logic [DQ_W+DR_W-1:0] day_prod;
	logic [TS_W-1:0]      day_base;
	logic [TS_W-1:0]      sod_full;
	logic [HQ_W+HR_W-1:0] hour_prod;
	logic [SOD_W-1:0]     hour_base;
	logic [SOD_W-1:0]     remh_full;
	logic [MQ_W+MR_W-1:0] min_prod;
	logic [REMH_W-1:0]    min_base;
	logic [REMH_W-1:0]    sec_full;

	logic               leap;
	logic               quad_ok;
	logic [DAYS_W-1:0]  ylen;
	logic [DAYS_W-1:0]  mlen;

	// one multiply or one multiply-and-subtract per cycle
	assign day_prod  = {{DR_W{1'b0}}, ts_q[TS_W-1:TS_W-DQ_W]} * {{DQ_W{1'b0}}, RECIP_DAY};
	assign day_base  = {{(TS_W-DAYS_W){1'b0}}, days_q} * SEC_PER_DAY;
	assign sod_full  = ts_q - day_base;
	assign hour_prod = {{HR_W{1'b0}}, sod_q[SOD_W-1:SOD_W-HQ_W]} *
		{{HQ_W{1'b0}}, RECIP_HOUR};
	assign hour_base = {{(SOD_W-HOUR_W){1'b0}}, hour_q} * SEC_PER_HOUR;
	assign remh_full = sod_q - hour_base;
	assign min_prod  = {{MR_W{1'b0}}, remh_q[REMH_W-1:REMH_W-MQ_W]} *
		{{MQ_W{1'b0}}, RECIP_MIN};
	assign min_base  = {{(REMH_W-MIN_W){1'b0}}, min_q} * SEC_PER_MIN;
	assign sec_full  = remh_q - min_base;

	// years stay within 1970..2106, so 2100 is the only century to skip
	assign leap    = (year_q[1:0] == 2'b00) && (year_q != SKIP_YEAR);
	assign ylen    = leap ? DAYS_LEAP : DAYS_YEAR;
	assign quad_ok = leap && (days_q >= DAYS_QUAD);
	assign mlen    = {{(DAYS_W-DAY_W){1'b0}}, month_len(mon_q, leap)};

	always_comb begin
		status.year_done  = !quad_ok && (days_q < ylen);
		status.month_done = (mon_q == LAST_MONTH) || (days_q < mlen);
		status.out_busy   = out_valid_q && date_stall;
	end

	always_ff @(posedge clk) begin
		if (cmd.load_in) begin
			ts_q <= unix_seconds;
		end
		if (cmd.div_day) begin
			days_q <= day_prod[DAY_SH+DAYS_W-1:DAY_SH];
		end
		if (cmd.rem_day) begin
			sod_q <= sod_full[SOD_W-1:0];
		end
		if (cmd.div_hour) begin
			hour_q <= hour_prod[HOUR_SH+HOUR_W-1:HOUR_SH];
		end
		if (cmd.rem_hour) begin
			remh_q <= remh_full[REMH_W-1:0];
		end
		if (cmd.div_min) begin
			min_q <= min_prod[MIN_SH+MIN_W-1:MIN_SH];
		end
		if (cmd.latch_sec) begin
			sec_q  <= sec_full[SEC_W-1:0];
			year_q <= EPOCH_YEAR;
			mon_q  <= '0;
		end
		if (cmd.year_step) begin
			// take four years at once from a leap year with no century inside
			if (quad_ok) begin
				days_q <= days_q - DAYS_QUAD;
				year_q <= year_q + 12'd4;
			end else if (days_q >= ylen) begin
				days_q <= days_q - ylen;
				year_q <= year_q + 12'd1;
			end
		end
		if (cmd.month_step && !status.month_done) begin
			days_q <= days_q - mlen;
			mon_q  <= mon_q + 4'd1;
		end
		if (cmd.out_load) begin
			year   <= year_q;
			month  <= mon_q + 4'd1;
			day    <= days_q[DAY_W-1:0] + 5'd1;
			hour   <= hour_q;
			minute <= min_q;
			second <= sec_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.out_load) begin
			out_valid_q <= 1'b1;
		end else if (!date_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	assign date_valid = out_valid_q;

endmodule

`default_nettype wire

/* hw/rtl/unix_time_to_calendar_date_top.sv */
// Top level of the Unix timestamp to Gregorian date converter.
// Depends on utcd_pkg, utcd_ctrl and utcd_dpath.
//
//  channel | handshake              | payload
//  --------+------------------------+------------------------------------------
//  request | ts_valid / ts_stall    | unix_seconds[31:0]
//  result  | date_valid / date_stall| year[11:0] month[3:0] day[4:0]
//          |                        | hour[4:0] minute[5:0] second[5:0]
//
// Each request walks the sequencer states in order; the next one is taken only
// when the sequencer is back in idle. The steps are the reciprocal divides and
// remainders (days, seconds of day, hours, seconds of hour, minutes, seconds), one
// year step per cycle plus a final check (four years at a time where no century
// intervenes, at most 40 steps), up to 11 month steps plus a check, and one output
// load, which waits while a stalled result holds the output register.
// Reset clears only the sequencer and the result valid flag; the datapath registers are not reset.
// A stalled result sits in the output register while the next request is
// accepted and converted; the new result waits until that one is taken.
`default_nettype none

module unix_time_to_calendar_date_top (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             ts_valid,
	output logic                                  ts_stall,
	input  wire logic [utcd_pkg::TS_W-1:0]        unix_seconds,
	output logic                                  date_valid,
	input  wire logic                             date_stall,
	output logic [utcd_pkg::YEAR_W-1:0]           year,
	output logic [utcd_pkg::MONTH_W-1:0]          month,
	output logic [utcd_pkg::DAY_W-1:0]            day,
	output logic [utcd_pkg::HOUR_W-1:0]           hour,
	output logic [utcd_pkg::MIN_W-1:0]            minute,
	output logic [utcd_pkg::SEC_W-1:0]            second
);
	import utcd_pkg::*;

	cmd_t    cmd;
	status_t status;

	// sequencer: accept a request only when idle, then step the datapath
	utcd_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.ts_valid (ts_valid),
		.ts_stall (ts_stall),
		.status   (status),
		.cmd      (cmd)
	);

	// dividers, calendar counters and the result register
	utcd_dpath u_dpath (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.status       (status),
		.unix_seconds (unix_seconds),
		.date_valid   (date_valid),
		.date_stall   (date_stall),
		.year         (year),
		.month        (month),
		.day          (day),
		.hour         (hour),
		.minute       (minute),
		.second       (second)
	);

endmodule

`default_nettype wire
